// ===== src/cos_pkg.sv =====
// Shared types and codes for the CoAP option stream parser.
package cos_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned WORD_W = 16;

   localparam logic [BYTE_W-1:0] MARKER_BYTE = 8'hFF;
   localparam logic [3:0]        NIB_EXT8    = 4'd13;
   localparam logic [3:0]        NIB_EXT16   = 4'd14;
   localparam logic [3:0]        NIB_BAD     = 4'd15;
   localparam logic [WORD_W-1:0] EXT8_BIAS   = 16'd13;
   localparam logic [WORD_W-1:0] EXT16_BIAS  = 16'd269;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_HEADER = 3'd1,
      PH_DEXT1  = 3'd2,
      PH_DEXT2  = 3'd3,
      PH_LEXT1  = 3'd4,
      PH_LEXT2  = 3'd5,
      PH_VALUE  = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      K_HEADER = 2'd0,
      K_VALUE  = 2'd1,
      K_MARKER = 2'd2,
      K_ERROR  = 2'd3
   } kind_type;

   typedef struct packed {
      phase_type         phase;
      logic [WORD_W-1:0] running_number;
      logic [WORD_W-1:0] pending_delta;
      logic [WORD_W-1:0] pending_length;
      logic [WORD_W-1:0] remaining_value;
      logic [3:0]        delta_nibble;
      logic [3:0]        length_nibble;
   } parse_state_type;

   typedef struct packed {
      logic              valid;
      kind_type          kind;
      logic [WORD_W-1:0] option_number;
      logic [WORD_W-1:0] option_length;
      logic [BYTE_W-1:0] value_byte;
      logic              option_end;
      logic              message_end;
   } result_type;

endpackage

// ===== src/coap_option_stream_parser.sv =====
// CoAP option area parser: top level with request register, parser state and result register.
//
// Feed the option area one byte per request, starting right after the token, with
// req_tuser marking the first option byte and req_tlast the final byte of the message.
// The block takes a request every cycle unless a held result waits on rsp_tready, and
// each byte's result is registered from the request register into the result register.
// The parser state register is updated once per byte by a combinational step. One result at most
// per byte: option header done, value byte, payload marker, or parse error; rsp_tlast
// flags the result that completes an option. After a marker, an error or a clean end,
// bytes are dropped until the next first byte.
module coap_option_stream_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] data_byte
   input  logic [0:0]  req_tuser,  // [0] first_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // [15:0] option_number, [31:16] option_length,
                                   // [39:32] value_byte
   output logic [2:0]  rsp_tuser,  // [1:0] kind, [2] message_end
   output logic        rsp_tlast   // option_end
);

   logic                           in_valid_ff;
   logic [cos_pkg::BYTE_W-1:0]     in_byte_ff;
   logic                           in_first_ff;
   logic                           in_last_ff;
   cos_pkg::parse_state_type       state_ff;
   cos_pkg::parse_state_type       state_in;
   logic [cos_pkg::BYTE_W-1:0]     ext_high_ff;
   logic                           ext_high_we;
   cos_pkg::result_type            result;
   cos_pkg::result_type            out_ff;
   logic                           advance;
   logic                           req_take;

   assign advance    = in_valid_ff && (!out_ff.valid || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   cos_step u_step (
      .state_cur    (state_ff),
      .ext_high_cur (ext_high_ff),
      .data_byte    (in_byte_ff),
      .first_byte   (in_first_ff),
      .last_byte    (in_last_ff),
      .state_nxt    (state_in),
      .ext_high_we  (ext_high_we),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff  <= req_tdata;
         in_first_ff <= req_tuser[0];
         in_last_ff  <= req_tlast;
      end
   end

   // all-zero state is idle
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && ext_high_we) begin
         ext_high_ff <= in_byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (advance) begin
         out_ff <= result;
      end else if (rsp_tready) begin
         out_ff.valid <= 1'b0;
      end
   end

   assign rsp_tvalid = out_ff.valid;
   assign rsp_tdata  = {out_ff.value_byte, out_ff.option_length, out_ff.option_number};
   assign rsp_tuser  = {out_ff.message_end, out_ff.kind};
   assign rsp_tlast  = out_ff.option_end;

   a_value_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == cos_pkg::PH_VALUE) |-> (state_ff.remaining_value != '0))
      else $error("value phase with nothing left");

   a_mend_needs_oend: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[2]) |-> rsp_tlast)
      else $error("message end without option end");

   a_term_kind_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (out_ff.kind == cos_pkg::K_ERROR || out_ff.kind == cos_pkg::K_MARKER))
      |-> (!rsp_tlast && rsp_tdata == '0))
      else $error("marker or error carries option fields");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && rsp_tvalid && !rsp_tready))
      else $error("request stalled without output backpressure");

endmodule

// ===== src/cos_step.sv =====
// Per-byte parse step: next parser state and the result for one request.
module cos_step (
   input  cos_pkg::parse_state_type         state_cur,
   input  logic [cos_pkg::BYTE_W-1:0]       ext_high_cur,
   input  logic [cos_pkg::BYTE_W-1:0]       data_byte,
   input  logic                             first_byte,
   input  logic                             last_byte,
   output cos_pkg::parse_state_type         state_nxt,
   output logic                             ext_high_we,
   output cos_pkg::result_type              result
);

   cos_pkg::phase_type             ph;
   logic [cos_pkg::WORD_W-1:0]     running_eff;
   logic [3:0]                     dn;
   logic [3:0]                     ln;
   logic [cos_pkg::WORD_W-1:0]     ext8;
   logic [cos_pkg::WORD_W-1:0]     ext16;
   logic [cos_pkg::WORD_W-1:0]     pd_new;
   logic [cos_pkg::WORD_W-1:0]     pl_new;
   logic [cos_pkg::WORD_W-1:0]     rem_new;
   logic [cos_pkg::WORD_W-1:0]     running_sum;
   logic                           is_marker;
   logic                           nib15;
   logic                           ad;
   logic                           hd;
   logic                           fail;

   // first_byte restarts the parse on this very byte
   assign ph          = first_byte ? cos_pkg::PH_HEADER : state_cur.phase;
   assign running_eff = first_byte ? '0 : state_cur.running_number;

   assign dn    = (ph == cos_pkg::PH_HEADER) ? data_byte[7:4] : state_cur.delta_nibble;
   assign ln    = (ph == cos_pkg::PH_HEADER) ? data_byte[3:0] : state_cur.length_nibble;
   assign ext8  = {8'd0, data_byte} + cos_pkg::EXT8_BIAS;
   assign ext16 = {ext_high_cur, data_byte} + cos_pkg::EXT16_BIAS;

   assign is_marker = (ph == cos_pkg::PH_HEADER) && (data_byte == cos_pkg::MARKER_BYTE);
   assign nib15     = (data_byte[7:4] == cos_pkg::NIB_BAD) || (data_byte[3:0] == cos_pkg::NIB_BAD);

   always_comb begin
      pd_new = state_cur.pending_delta;
      pl_new = state_cur.pending_length;
      case (ph)
         cos_pkg::PH_HEADER: begin
            pd_new = {12'd0, data_byte[7:4]};
            pl_new = {12'd0, data_byte[3:0]};
         end
         cos_pkg::PH_DEXT1: begin
            if (dn == cos_pkg::NIB_EXT8) pd_new = ext8;
         end
         cos_pkg::PH_DEXT2: pd_new = ext16;
         cos_pkg::PH_LEXT1: begin
            if (ln == cos_pkg::NIB_EXT8) pl_new = ext8;
         end
         cos_pkg::PH_LEXT2: pl_new = ext16;
         default: ;
      endcase
   end

   assign rem_new = (state_cur.remaining_value != '0) ?
                    state_cur.remaining_value - 16'd1 : state_cur.remaining_value;
   assign running_sum = running_eff + pd_new;

   // ad: delta fully known; hd: whole header known
   assign ad = ((ph == cos_pkg::PH_HEADER) && !is_marker && !nib15 && (dn < cos_pkg::NIB_EXT8))
            || ((ph == cos_pkg::PH_DEXT1) && (dn == cos_pkg::NIB_EXT8))
            || (ph == cos_pkg::PH_DEXT2);
   assign hd = (ad && (ln < cos_pkg::NIB_EXT8))
            || ((ph == cos_pkg::PH_LEXT1) && (ln == cos_pkg::NIB_EXT8))
            || (ph == cos_pkg::PH_LEXT2);

   assign fail = ((ph == cos_pkg::PH_HEADER) && !is_marker && nib15)
              || ((ph == cos_pkg::PH_HEADER) && !is_marker && !nib15
                  && (dn >= cos_pkg::NIB_EXT8) && last_byte)
              || ((ph == cos_pkg::PH_DEXT1) && (dn != cos_pkg::NIB_EXT8) && last_byte)
              || (ad && (ln >= cos_pkg::NIB_EXT8) && last_byte)
              || ((ph == cos_pkg::PH_LEXT1) && (ln != cos_pkg::NIB_EXT8) && last_byte)
              || (hd && (pl_new != '0) && last_byte)
              || ((ph == cos_pkg::PH_VALUE) && (rem_new != '0) && last_byte);

   assign ext_high_we = ((ph == cos_pkg::PH_DEXT1) && (dn != cos_pkg::NIB_EXT8))
                     || ((ph == cos_pkg::PH_LEXT1) && (ln != cos_pkg::NIB_EXT8));

   // next state
   always_comb begin
      state_nxt                 = state_cur;
      state_nxt.running_number  = running_eff;
      state_nxt.pending_delta   = pd_new;
      state_nxt.pending_length  = pl_new;
      state_nxt.delta_nibble    = dn;
      state_nxt.length_nibble   = ln;
      if (hd && !fail) begin
         state_nxt.running_number  = running_sum;
         state_nxt.remaining_value = pl_new;
      end else if (ph == cos_pkg::PH_VALUE) begin
         state_nxt.remaining_value = rem_new;
      end

      if (fail || is_marker) begin
         state_nxt.phase = cos_pkg::PH_IDLE;
      end else if (hd) begin
         if (pl_new != '0)   state_nxt.phase = cos_pkg::PH_VALUE;
         else if (last_byte) state_nxt.phase = cos_pkg::PH_IDLE;
         else                state_nxt.phase = cos_pkg::PH_HEADER;
      end else if (ad) begin
         state_nxt.phase = cos_pkg::PH_LEXT1;
      end else begin
         case (ph)
            cos_pkg::PH_HEADER: state_nxt.phase = cos_pkg::PH_DEXT1;
            cos_pkg::PH_DEXT1:  state_nxt.phase = cos_pkg::PH_DEXT2;
            cos_pkg::PH_LEXT1:  state_nxt.phase = cos_pkg::PH_LEXT2;
            cos_pkg::PH_VALUE: begin
               if (rem_new != '0)  state_nxt.phase = cos_pkg::PH_VALUE;
               else if (last_byte) state_nxt.phase = cos_pkg::PH_IDLE;
               else                state_nxt.phase = cos_pkg::PH_HEADER;
            end
            default:            state_nxt.phase = cos_pkg::PH_IDLE;
         endcase
      end
   end

   // result
   always_comb begin
      result = '0;
      if (fail) begin
         result.valid = 1'b1;
         result.kind  = cos_pkg::K_ERROR;
      end else if (is_marker) begin
         result.valid = 1'b1;
         result.kind  = cos_pkg::K_MARKER;
      end else if (hd) begin
         result.valid         = 1'b1;
         result.kind          = cos_pkg::K_HEADER;
         result.option_number = running_sum;
         result.option_length = pl_new;
         result.option_end    = (pl_new == '0);
         result.message_end   = (pl_new == '0) && last_byte;
      end else if (ph == cos_pkg::PH_VALUE) begin
         result.valid         = 1'b1;
         result.kind          = cos_pkg::K_VALUE;
         result.option_number = running_eff;
         result.option_length = state_cur.pending_length;
         result.value_byte    = data_byte;
         result.option_end    = (rem_new == '0);
         result.message_end   = (rem_new == '0) && last_byte;
      end
   end

endmodule
